// File: rtl/quad_corner_projector_defines.svh
// assertion macros used by the checker file of the quad corner projector
`ifndef QUAD_CORNER_PROJECTOR_DEFINES_SVH
`define QUAD_CORNER_PROJECTOR_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define QCP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("quad corner projector check failed");

// antecedent implies consequent in the next cycle
`define QCP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("quad corner projector check failed");

`endif

// File: rtl/qcp_pkg.sv
// package with types, codes and sizes of the quad corner projector
`default_nettype none

package qcp_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int BONE_COUNT = 64;
    localparam int BONE_W     = $clog2(BONE_COUNT);
    localparam int TBL_AW     = BONE_W + 4;
    localparam int ACC_W      = 64 - FRAC_BITS + 2;
    localparam int P_W        = 48;
    localparam int NUM_W      = P_W + FRAC_BITS;
    localparam int DIV_CW     = $clog2(NUM_W);

    // input commands
    localparam logic [2:0] CMD_VIEW   = 3'd0;
    localparam logic [2:0] CMD_PROJ   = 3'd1;
    localparam logic [2:0] CMD_BONE   = 3'd2;
    localparam logic [2:0] CMD_VIS    = 3'd3;
    localparam logic [2:0] CMD_CORNER = 3'd4;

    // transform stages
    localparam logic [1:0] STG_BONE = 2'd0;
    localparam logic [1:0] STG_VIEW = 2'd1;
    localparam logic [1:0] STG_PROJ = 2'd2;

    // configuration register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic       accept;
        logic       load_in;
        logic       issue;
        logic [1:0] stage;
        logic [3:0] k;
        logic       copy;
        logic       num_load;
        logic       mag_load;
        logic       div_start;
        logic       div_sel_y;
        logic       out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic bad;
        logic div_done;
        logic out_full;
    } t_dp_sts;

endpackage

`default_nettype wire

// File: rtl/qcp_divider.sv
// restoring divider, one quotient bit per cycle
`default_nettype none

module qcp_divider import qcp_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_dividend,
    input  wire logic [31:0]      i_divisor,
    output logic                  o_done,
    output logic [NUM_W-1:0]      o_quot
);

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [NUM_W-1:0]  r_q;
    logic [31:0]       r_rem;
    logic [31:0]       r_den;
    logic [32:0]       rem_sh;
    logic [32:0]       rem_sub;
    logic              q_bit;

    // trial subtract of the shifted remainder
    always_comb begin
        rem_sh  = {r_rem, r_q[NUM_W-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        q_bit   = (rem_sh >= {1'b0, r_den});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CW'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient and remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[NUM_W-2:0], q_bit};
            r_rem <= q_bit ? rem_sub[31:0] : rem_sh[31:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

`default_nettype wire

// File: rtl/qcp_datapath.sv
// datapath: matrix stores, multiply-accumulate, clip tests, division, result register
`default_nettype none

module qcp_datapath import qcp_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_dp_cmd            i_cmd,
    output t_dp_sts                 o_sts,
    input  wire logic [2:0]         i_command,
    input  wire logic [5:0]         i_bone_sel,
    input  wire logic [3:0]         i_element_index,
    input  wire logic signed [31:0] i_element_value,
    input  wire logic [1:0]         i_corner_number,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic signed [31:0] i_pos_z,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_addr,
    input  wire logic [13:0]        i_cfg_wdata,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    output logic [127:0]            o_out_data,
    output logic [1:0]              o_out_user,
    output logic                    o_out_last
);

    // configuration and persistent state
    logic [13:0]           r_vw, r_vh;
    logic [BONE_COUNT-1:0] r_vis;
    logic                  r_fsv;
    logic [33:0]           r_facc;
    logic                  r_oval;

    // matrix stores
    logic signed [31:0] r_view_mem [16];
    logic signed [31:0] r_proj_mem [16];
    logic signed [31:0] r_bone_mem [BONE_COUNT*16];
    logic signed [31:0] r_view_rd, r_proj_rd, r_bone_rd;

    // corner payload
    logic [BONE_W-1:0]     r_bone;
    logic [1:0]            r_corner;
    logic signed [31:0]    r_vin [4];
    logic signed [31:0]    r_res [4];
    logic signed [31:0]    r_vz;
    logic [31:0]           r_d;
    logic [31:0]           r_den;
    logic signed [P_W-1:0] r_px, r_py;
    logic [NUM_W-1:0]      r_magx, r_magy;
    logic                  r_negx, r_negy;
    logic signed [31:0]    r_sx, r_sy;

    // multiply-accumulate pipeline
    logic                    r_t1_v, r_t2_v;
    logic [3:0]              r_t1_k, r_t2_k;
    logic signed [ACC_W-1:0] r_term, r_acc;
    logic                    r_bad, r_sel_y;

    logic [3:0]              rd_e;
    logic                    bone_ok;
    logic signed [31:0]      elem, vsel;
    logic signed [63:0]      prod;
    logic signed [ACC_W-1:0] term, sum;
    logic                    row_end, row_ovf;

    // stores are read at column-major element positions
    assign rd_e    = {i_cmd.k[1:0], i_cmd.k[3:2]};
    assign bone_ok = (32'(i_bone_sel) < BONE_COUNT);

    // element select and product
    always_comb begin
        case (i_cmd.stage)
            STG_BONE: elem = r_bone_rd;
            STG_VIEW: elem = r_view_rd;
            default:  elem = r_proj_rd;
        endcase
        vsel = r_vin[r_t1_k[1:0]];
        prod = elem * vsel;
        if ((i_cmd.stage == STG_BONE) && (r_t1_k[1:0] == 2'd3)) begin
            term = {{(ACC_W-32){elem[31]}}, elem};
        end else begin
            term = {{2{prod[63]}}, prod[63:FRAC_BITS]};
        end
        sum     = r_acc + r_term;
        row_end = r_t2_v && (r_t2_k[1:0] == 2'd3);
        row_ovf = !((&sum[ACC_W-1:31]) || !(|sum[ACC_W-1:31]));
    end

    // clip tests and screen numerators
    logic signed [32:0] w33, c2_33, d33, ax, ay;
    logic               chk_bad;
    always_comb begin
        w33   = {r_res[3][31], r_res[3]};
        c2_33 = {r_res[2][31], r_res[2]};
        d33   = 33'sd0 - {r_vz[31], r_vz};
        ax    = {r_res[0][31], r_res[0]} + w33;
        ay    = w33 - {r_res[1][31], r_res[1]};
        chk_bad = (d33[32] != d33[31]) || (w33 <= 33'sd0) || (d33 <= 33'sd0)
               || (c2_33 < -w33) || (c2_33 > w33);
    end

    // magnitudes of the scaled numerators, rounded for floor division
    logic signed [P_W-1:0] pnx, pny;
    logic [NUM_W-1:0]      mx, my;
    always_comb begin
        pnx = -r_px;
        pny = -r_py;
        mx  = r_px[P_W-1] ? ({pnx, {FRAC_BITS{1'b0}}} + NUM_W'(r_den) - NUM_W'(1))
                          : {r_px, {FRAC_BITS{1'b0}}};
        my  = r_py[P_W-1] ? ({pny, {FRAC_BITS{1'b0}}} + NUM_W'(r_den) - NUM_W'(1))
                          : {r_py, {FRAC_BITS{1'b0}}};
    end

    // shared divider
    logic             div_done;
    logic [NUM_W-1:0] quot, quot_n;
    logic             div_neg, div_ovf;
    logic [31:0]      div_res;

    qcp_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (i_cmd.div_sel_y ? r_magy : r_magx),
        .i_divisor  (r_den),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    always_comb begin
        div_neg = r_sel_y ? r_negy : r_negx;
        quot_n  = NUM_W'(0) - quot;
        div_ovf = div_neg ? (quot > (NUM_W'(1) << 31)) : (quot >= (NUM_W'(1) << 31));
        div_res = div_neg ? quot_n[31:0] : quot[31:0];
    end

    // face state update and result fields
    logic        ok, base_fsv, n_fsv, face_done, face_valid;
    logic [33:0] base_acc, n_facc;
    always_comb begin
        ok         = !r_bad;
        base_fsv   = (r_corner == 2'd0) || r_fsv;
        base_acc   = (r_corner == 2'd0) ? 34'd0 : r_facc;
        n_fsv      = base_fsv && ok;
        n_facc     = ok ? (base_acc + {2'b00, r_d}) : base_acc;
        face_done  = (r_corner == 2'd3);
        face_valid = face_done && n_fsv;
    end

    // configuration, visibility, face state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vw   <= '0;
            r_vh   <= '0;
            r_vis  <= '0;
            r_fsv  <= 1'b1;
            r_facc <= '0;
            r_oval <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_WIDTH:  r_vw <= i_cfg_wdata;
                    REG_HEIGHT: r_vh <= i_cfg_wdata;
                    default:    r_vw <= r_vw;
                endcase
            end
            if (i_cmd.accept && (i_command == CMD_VIS) && bone_ok) begin
                r_vis[i_bone_sel[BONE_W-1:0]] <= (i_element_value != 32'sd0);
            end
            if (i_cmd.out_load) begin
                r_fsv  <= n_fsv;
                r_facc <= n_facc;
                r_oval <= 1'b1;
            end else if (i_out_ready) begin
                r_oval <= 1'b0;
            end
        end
    end

    // matrix store writes and registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            case (i_command)
                CMD_VIEW: r_view_mem[i_element_index] <= i_element_value;
                CMD_PROJ: r_proj_mem[i_element_index] <= i_element_value;
                CMD_BONE: begin
                    if (bone_ok) begin
                        r_bone_mem[{i_bone_sel[BONE_W-1:0], i_element_index}]
                            <= i_element_value;
                    end
                end
                default: ;
            endcase
        end
        r_view_rd <= r_view_mem[rd_e];
        r_proj_rd <= r_proj_mem[rd_e];
        r_bone_rd <= r_bone_mem[{r_bone, rd_e}];
    end

    // pipeline control and reject flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_v  <= 1'b0;
            r_t2_v  <= 1'b0;
            r_bad   <= 1'b0;
            r_sel_y <= 1'b0;
        end else begin
            r_t1_v <= i_cmd.issue;
            r_t2_v <= r_t1_v;
            if (i_cmd.div_start) begin
                r_sel_y <= i_cmd.div_sel_y;
            end
            if (i_cmd.load_in) begin
                r_bad <= !((r_vw != 14'd0) && (r_vh != 14'd0) && bone_ok
                           && r_vis[i_bone_sel[BONE_W-1:0]]);
            end else begin
                if (row_end && row_ovf) r_bad <= 1'b1;
                if (i_cmd.num_load && chk_bad) r_bad <= 1'b1;
                if (div_done && div_ovf) r_bad <= 1'b1;
            end
        end
    end

    // corner payload and arithmetic registers
    always_ff @(posedge i_clk) begin
        r_t1_k <= i_cmd.k;
        r_t2_k <= r_t1_k;
        r_term <= term;
        if (i_cmd.load_in) begin
            r_bone   <= i_bone_sel[BONE_W-1:0];
            r_corner <= i_corner_number;
            r_vin[0] <= i_pos_x;
            r_vin[1] <= i_pos_y;
            r_vin[2] <= i_pos_z;
            r_vin[3] <= 32'sd0;
            r_acc    <= '0;
        end else if (r_t2_v) begin
            if (row_end) begin
                r_res[r_t2_k[3:2]] <= sum[31:0];
                r_acc <= '0;
            end else begin
                r_acc <= sum;
            end
        end
        if (i_cmd.copy) begin
            r_vin <= r_res;
            if (i_cmd.stage == STG_VIEW) r_vz <= r_res[2];
        end
        if (i_cmd.num_load) begin
            r_d   <= d33[31:0];
            r_den <= {r_res[3][30:0], 1'b0};
            r_px  <= ax * $signed({1'b0, r_vw});
            r_py  <= ay * $signed({1'b0, r_vh});
        end
        if (i_cmd.mag_load) begin
            r_magx <= mx;
            r_magy <= my;
            r_negx <= r_px[P_W-1];
            r_negy <= r_py[P_W-1];
        end
        if (div_done) begin
            if (r_sel_y) r_sy <= div_res;
            else         r_sx <= div_res;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_out_data[31:0]   <= ok ? r_sx : 32'd0;
            o_out_data[63:32]  <= ok ? r_sy : 32'd0;
            o_out_data[95:64]  <= ok ? r_d  : 32'd0;
            o_out_data[127:96] <= face_valid ? n_facc[33:2] : 32'd0;
            o_out_user         <= {face_valid, ok};
            o_out_last         <= face_done;
        end
    end

    assign o_out_valid    = r_oval;
    assign o_sts.bad      = r_bad;
    assign o_sts.div_done = div_done;
    assign o_sts.out_full = r_oval;

endmodule

`default_nettype wire

// File: rtl/qcp_controller.sv
// controller: sequences the transform stages, tests and divisions of a corner
`default_nettype none

module qcp_controller import qcp_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [2:0] i_command,
    input  wire logic       i_out_ready,
    input  wire t_dp_sts    i_sts,
    output logic            o_ready,
    output t_dp_cmd         o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MAT   = 9'b000000010,
        S_DRAIN = 9'b000000100,
        S_CHK   = 9'b000001000,
        S_MAG   = 9'b000010000,
        S_DEC   = 9'b000100000,
        S_DIVX  = 9'b001000000,
        S_DIVY  = 9'b010000000,
        S_FIN   = 9'b100000000
    } t_state;

    t_state     r_state, n_state;
    logic [3:0] r_k, n_k;
    logic [1:0] r_stage, n_stage;
    logic [1:0] r_drain, n_drain;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_stage = r_stage;
        n_drain = r_drain;
        o_cmd   = '0;
        o_cmd.stage = r_stage;
        o_cmd.k     = r_k;
        o_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_valid;
                if (i_valid && (i_command == CMD_CORNER)) begin
                    o_cmd.load_in = 1'b1;
                    n_stage = STG_BONE;
                    n_k     = '0;
                    n_state = S_MAT;
                end
            end
            S_MAT: begin
                o_cmd.issue = 1'b1;
                n_k = r_k + 1'b1;
                if (r_k == 4'd15) begin
                    n_drain = '0;
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_drain = r_drain + 1'b1;
                if (r_drain == 2'd2) begin
                    o_cmd.copy = 1'b1;
                    if (r_stage == STG_PROJ) begin
                        n_state = S_CHK;
                    end else begin
                        n_stage = r_stage + 1'b1;
                        n_state = S_MAT;
                    end
                end
            end
            S_CHK: begin
                o_cmd.num_load = 1'b1;
                n_state = S_MAG;
            end
            S_MAG: begin
                o_cmd.mag_load = 1'b1;
                n_state = S_DEC;
            end
            S_DEC: begin
                if (i_sts.bad) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIVX;
                end
            end
            S_DIVX: begin
                if (i_sts.div_done) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel_y = 1'b1;
                    n_state = S_DIVY;
                end
            end
            S_DIVY: begin
                if (i_sts.div_done) n_state = S_FIN;
            end
            S_FIN: begin
                if (!i_sts.out_full || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_stage <= STG_BONE;
            r_drain <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_stage <= n_stage;
            r_drain <= n_drain;
        end
    end

endmodule

`default_nettype wire

// File: rtl/quad_corner_projector.sv
// top level of the quad corner projector
// Input stream: tuser carries the command, tdata the load and corner fields.
// Load commands (view, projection, bone element, bone visibility) produce
// no output transaction. A project-corner command runs three 4x4
// transforms on one shared 32x32 multiplier, one product a cycle, then
// the clip tests and two floor divisions on a shared radix-2 divider; a
// corner rejected before the divisions skips them. One corner is worked
// on at a time; the input is ready again as soon as the result moves
// into the output register, so the next item is taken while a result
// still waits to be taken.
// Output stream: one transaction per corner; tlast marks the fourth corner
// with the face result. A stalled receiver holds the output register and,
// once the next result is finished, the block waits for it.
// Reset clears the viewport size, the bone visibility flags and the face
// state; the matrix stores hold nothing defined until loaded.
`default_nettype none

module quad_corner_projector import qcp_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // bone, element_index, element_value, corner_number, pos_x, pos_y, pos_z
    input  wire logic [143:0] s_axis_tdata,
    // command
    input  wire logic [2:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // screen_x, screen_y, corner_depth, face_depth
    output logic [127:0]      m_axis_tdata,
    // corner_ok, face_valid
    output logic [1:0]        m_axis_tuser,
    // face_done
    output logic              m_axis_tlast,
    input  wire logic         i_cfg_we,
    input  wire logic         i_cfg_addr,
    input  wire logic [13:0]  i_cfg_wdata
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // corner sequencing
    qcp_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .i_command   (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_ready     (s_axis_tready),
        .o_cmd       (cmd)
    );

    // arithmetic and storage
    qcp_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_command       (s_axis_tuser),
        .i_bone_sel      (s_axis_tdata[5:0]),
        .i_element_index (s_axis_tdata[9:6]),
        .i_element_value (s_axis_tdata[41:10]),
        .i_corner_number (s_axis_tdata[43:42]),
        .i_pos_x         (s_axis_tdata[75:44]),
        .i_pos_y         (s_axis_tdata[107:76]),
        .i_pos_z         (s_axis_tdata[139:108]),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_out_data      (m_axis_tdata),
        .o_out_user      (m_axis_tuser),
        .o_out_last      (m_axis_tlast)
    );

endmodule

`default_nettype wire

// File: rtl/qcp_checker.sv
// port-level checker of the quad corner projector and its bind
`default_nettype none

`include "quad_corner_projector_defines.svh"

module qcp_port_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [127:0] m_axis_tdata,
    input wire logic [1:0]   m_axis_tuser,
    input wire logic         m_axis_tlast
);

    // a stalled result holds
    `QCP_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    // rejected corner carries zero coordinates and depth
    `QCP_ASSERT_IMP(a_reject_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[95:0] == 96'd0)
    // face fields only on the fourth corner
    `QCP_ASSERT_IMP(a_face_last, m_axis_tvalid && m_axis_tuser[1], m_axis_tlast && m_axis_tuser[0])
    // invalid face reports zero depth
    `QCP_ASSERT_IMP(a_face_zero, m_axis_tvalid && !m_axis_tuser[1], m_axis_tdata[127:96] == 32'd0)

endmodule

bind quad_corner_projector qcp_port_checker u_qcp_port_checker (.*);

`default_nettype wire
